@@ rtl/core/salru_pkg.sv @@
// Shared constants and codes for the set-associative LRU cache model.
`timescale 1ns / 1ps
package salru_pkg;

	// Default geometry and counter width
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int WAYS_DEF         = 8;
	localparam int COUNT_BITS_DEF   = 32;

	// Fixed field widths
	localparam int ADDR_W      = 64;
	localparam int TAG_W       = 63;
	localparam int OUTCOME_W   = 2;
	localparam int WAY_OUT_W   = 3;
	localparam int TOTAL_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int SET_CFG_W   = 3;
	localparam int OFS_CFG_W   = 6;
	localparam int WAYS_CFG_W  = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_OFFSET_BITS = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_idx_t;

	// Lookup outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

endpackage

@@ rtl/core/salru_if.sv @@
// Request and response channel interfaces of the LRU cache model.
`timescale 1ns / 1ps
interface salru_req_if;
	logic        valid;
	logic        ready;
	logic [63:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface salru_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [2:0]  way_used;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;

	modport source (output valid, output outcome, output way_used, output hit_total,
		output miss_total, output eviction_total, input ready);
	modport sink   (input valid, input outcome, input way_used, input hit_total,
		input miss_total, input eviction_total, output ready);
endinterface

@@ rtl/core/set_assoc_cache_lru_sim_core.sv @@
// Set-associative tag store with true LRU ranks, hit/miss/eviction totals.
// Pipeline: the set row is read into the stage-one register at the accepting edge, then the
// tag compare and LRU update are written into the result register once it is free.
// One address per cycle unless stalled; a same-set follow-on is forwarded from the row write.
// Reset: control and totals clear at once; a clearing sweep then zeroes one set row
// per cycle across all 2^MAX_SET_BITS rows (64 by default) while no address is accepted.
`timescale 1ns / 1ps
module set_assoc_cache_lru_sim_core
	import salru_pkg::*;
#(
	parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
	parameter int WAYS         = WAYS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	salru_req_if.sink             req,
	salru_rsp_if.source           rsp
);

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_OFS  = WAYS + WAYS * RANK_W;
	localparam int ROW_W    = WAYS * (1 + RANK_W + TAG_W);

	// Configuration registers
	logic [SET_CFG_W-1:0]  set_bits_q;
	logic [OFS_CFG_W-1:0]  offset_bits_q;
	logic [WAYS_CFG_W-1:0] ways_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			offset_bits_q <= OFS_CFG_W'(1);
			ways_in_use_q <= WAYS_CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SET_BITS:    set_bits_q    <= cfg_wdata[SET_CFG_W-1:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata[OFS_CFG_W-1:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[WAYS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic             clr_busy_q;
	logic [SET_W-1:0] clr_cnt_q;
	logic             vld_s1;
	logic             out_vld_q;
	logic             adv;
	logic             accept;
	logic             retire;

	assign adv       = !out_vld_q || rsp.ready;
	assign retire    = vld_s1 && adv;
	assign req.ready = !clr_busy_q && (!vld_s1 || adv);
	assign accept    = req.valid && req.ready;

	// Split the incoming address into set index and tag
	logic [OFS_CFG_W-1:0] ob;
	logic [SET_CFG_W-1:0] sb;
	logic [ADDR_W-1:0]    addr_shift;
	logic [ADDR_W-1:0]    set_full;
	logic [6:0]           tshift;
	logic [ADDR_W-1:0]    tag_shift;
	logic [SET_W-1:0]     set_in;
	logic [TAG_W-1:0]     tag_in;

	always_comb begin
		ob = (offset_bits_q == '0) ? OFS_CFG_W'(1) : offset_bits_q;
		sb = ({1'b0, set_bits_q} > 4'(MAX_SET_BITS)) ? SET_CFG_W'(MAX_SET_BITS) : set_bits_q;
		addr_shift = req.address >> ob;
		set_full   = addr_shift & ~({ADDR_W{1'b1}} << sb);
		set_in     = set_full[SET_W-1:0];
		tshift     = 7'(ob) + 7'(sb);
		tag_shift  = req.address >> tshift;
		tag_in     = tshift[6] ? '0 : tag_shift[TAG_W-1:0];
	end

	// Set row memory and stage-one registers
	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [ROW_W-1:0] rdata_s1;
	logic [ROW_W-1:0] fwd_row_s1;
	logic             fwd_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [ROW_W-1:0] new_row;
	logic             mem_we;
	logic [SET_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	assign mem_we    = clr_busy_q || retire;
	assign mem_waddr = clr_busy_q ? clr_cnt_q : set_s1;
	assign mem_wdata = clr_busy_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rdata_s1 <= mem[set_in];
		end
	end

	// Hold the item's set, tag and forwarded row
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1     <= set_in;
			tag_s1     <= tag_in;
			fwd_s1     <= retire && (set_s1 == set_in);
			fwd_row_s1 <= new_row;
		end
	end

	// Stage valid and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (retire) begin
				vld_s1 <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + SET_W'(1);
				if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// Unpack the current row
	logic [ROW_W-1:0]             cur_row;
	logic [WAYS-1:0]              cur_valid;
	logic [WAYS-1:0][RANK_W-1:0]  cur_rank;
	logic [WAYS-1:0][TAG_W-1:0]   cur_tag;

	assign cur_row = fwd_s1 ? fwd_row_s1 : rdata_s1;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			cur_valid[i] = cur_row[i];
			cur_rank[i]  = cur_row[WAYS + i * RANK_W +: RANK_W];
			cur_tag[i]   = cur_row[TAG_OFS + i * TAG_W +: TAG_W];
		end
	end

	// Compare ways, pick the way, update LRU ranks
	logic [WAYS-1:0]   act;
	logic [WAYS-1:0]   hit_vec;
	logic [WAYS-1:0]   empty_vec;
	logic [WAYS-1:0]   max_vec;
	logic [WAY_W-1:0]  hit_w;
	logic [WAY_W-1:0]  empty_w;
	logic [WAY_W-1:0]  vict_w;
	logic [WAY_W-1:0]  way;
	logic [RANK_W:0]   old_rank;
	outcome_t          outcome;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			act[i]       = (i == 0) || (ways_in_use_q > WAYS_CFG_W'(i));
			hit_vec[i]   = act[i] && cur_valid[i] && (cur_tag[i] == tag_s1);
			empty_vec[i] = act[i] && !cur_valid[i];
		end
		for (int i = 0; i < WAYS; i++) begin
			max_vec[i] = act[i];
			for (int j = 0; j < WAYS; j++) begin
				if (act[j] && (cur_rank[j] > cur_rank[i])) begin
					max_vec[i] = 1'b0;
				end
			end
		end
		hit_w   = '0;
		empty_w = '0;
		vict_w  = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_w = WAY_W'(i);
			end
			if (empty_vec[i]) begin
				empty_w = WAY_W'(i);
			end
			if (max_vec[i]) begin
				vict_w = WAY_W'(i);
			end
		end
		if (|hit_vec) begin
			outcome  = OUT_HIT;
			way      = hit_w;
			old_rank = {1'b0, cur_rank[hit_w]};
		end else if (|empty_vec) begin
			outcome  = OUT_FILL;
			way      = empty_w;
			old_rank = (RANK_W + 1)'(WAYS);
		end else begin
			outcome  = OUT_EVICT;
			way      = vict_w;
			old_rank = {1'b0, cur_rank[vict_w]};
		end
		new_row = cur_row;
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) == way) begin
				new_row[i]                              = 1'b1;
				new_row[WAYS + i * RANK_W +: RANK_W]    = '0;
				new_row[TAG_OFS + i * TAG_W +: TAG_W]   = tag_s1;
			end else if (act[i] && cur_valid[i] && ({1'b0, cur_rank[i]} < old_rank)
				&& (cur_rank[i] < RANK_W'(WAYS - 1))) begin
				new_row[WAYS + i * RANK_W +: RANK_W] = cur_rank[i] + RANK_W'(1);
			end
		end
	end

	// Saturating totals
	logic [COUNT_BITS-1:0] hits_q;
	logic [COUNT_BITS-1:0] misses_q;
	logic [COUNT_BITS-1:0] evicts_q;
	logic [COUNT_BITS-1:0] hits_nxt;
	logic [COUNT_BITS-1:0] misses_nxt;
	logic [COUNT_BITS-1:0] evicts_nxt;

	always_comb begin
		hits_nxt   = hits_q;
		misses_nxt = misses_q;
		evicts_nxt = evicts_q;
		if (outcome == OUT_HIT) begin
			if (hits_q != '1) begin
				hits_nxt = hits_q + COUNT_BITS'(1);
			end
		end else begin
			if (misses_q != '1) begin
				misses_nxt = misses_q + COUNT_BITS'(1);
			end
			if ((outcome == OUT_EVICT) && (evicts_q != '1)) begin
				evicts_nxt = evicts_q + COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (retire) begin
			hits_q   <= hits_nxt;
			misses_q <= misses_nxt;
			evicts_q <= evicts_nxt;
		end
	end

	// Result register
	logic [OUTCOME_W-1:0] outcome_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [TOTAL_W-1:0]   hit_tot_q;
	logic [TOTAL_W-1:0]   miss_tot_q;
	logic [TOTAL_W-1:0]   evict_tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (retire) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			outcome_q   <= outcome;
			way_q       <= WAY_OUT_W'(way);
			hit_tot_q   <= TOTAL_W'(hits_nxt);
			miss_tot_q  <= TOTAL_W'(misses_nxt);
			evict_tot_q <= TOTAL_W'(evicts_nxt);
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.outcome        = outcome_q;
	assign rsp.way_used       = way_q;
	assign rsp.hit_total      = hit_tot_q;
	assign rsp.miss_total     = miss_tot_q;
	assign rsp.eviction_total = evict_tot_q;

endmodule
